// ===== hw/rtl/mln_pkg.sv =====
// ----------------------------------------------------------------------------
// mln_pkg
// Shared types and constants for the modulated layer norm block.
// ----------------------------------------------------------------------------
package mln_pkg;

   localparam int DEF_MAX_ROW = 4096;
   localparam int ROW_W       = 13;
   localparam int EPS_W       = 32;
   localparam int DATA_W      = 16;
   localparam int ENT_W       = 3 * DATA_W;
   localparam int WORD_W      = 64;
   localparam int SUM_W       = 30;
   localparam int SQ_W        = 44;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int MAG_W       = 42;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EPSILON    = 1'd1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [ROW_W-1:0] ROW_LENGTH_RST = 13'd4096;
   localparam logic [EPS_W-1:0] EPSILON_RST    = 32'd17;

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_SUM      = 15'b000000000000010,
      ST_MUL_NQ   = 15'b000000000000100,
      ST_MUL_SS   = 15'b000000000001000,
      ST_MUL_NN   = 15'b000000000010000,
      ST_DIV_VAR  = 15'b000000000100000,
      ST_DIV_MEAN = 15'b000000001000000,
      ST_DIV_INV  = 15'b000000010000000,
      ST_SQRT     = 15'b000000100000000,
      ST_RD       = 15'b000001000000000,
      ST_LATCH    = 15'b000010000000000,
      ST_MUL_C    = 15'b000100000000000,
      ST_MUL_F    = 15'b001000000000000,
      ST_FIN1     = 15'b010000000000000,
      ST_FIN2     = 15'b100000000000000
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage

// ===== hw/rtl/modulated_layer_norm.sv =====
// ----------------------------------------------------------------------------
// modulated_layer_norm
// Row layer norm with per-element shift and scale modulation.
// ----------------------------------------------------------------------------
// A load transaction stores value, shift and scale. The first drain on a full
// row runs the statistics: one read pass over the row, then three shift-add
// multiplies, three divides and a square root. Every drain then reaches a
// valid response by way of two passes through the shift-add multiplier. The
// block accepts nothing while busy or while a result waits on the response
// channel.
// ----------------------------------------------------------------------------
module modulated_layer_norm import mln_pkg::*; #(
   parameter int MAX_ROW = DEF_MAX_ROW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic signed [15:0]    req_sample,
   input  logic signed [15:0]    req_shift_term,
   input  logic signed [15:0]    req_scale_term,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_normalized,
   output logic                  rsp_row_end,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW    = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
   localparam int CNT_W = (AW > ROW_W) ? AW : ROW_W;

   state_type         state_ff, state_in;
   logic              launch_ff, launch_in;
   logic [ROW_W-1:0]  row_len_ff;
   logic [EPS_W-1:0]  eps_ff;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  drain_ff, drain_in;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic              stats_ff, stats_in;
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0]       inv_ff, inv_in;
   logic signed [SUM_W-1:0] s_ff;
   logic [SQ_W-1:0]   q_ff;
   logic [WORD_W-1:0] num_ff, num_in;
   logic [WORD_W-1:0] nn_ff, nn_in;
   logic [WORD_W-1:0] dd_ff, dd_in;
   logic signed [33:0] c_ff, c_in;
   logic signed [15:0] sh_ff, sh_in;
   logic signed [17:0] f_ff, f_in;
   logic [MAG_W-1:0]  mmag_ff, mmag_in;
   logic              mneg_ff, mneg_in;
   logic signed [WORD_W-1:0] mf_ff, mf_in;
   logic signed [WORD_W-1:0] t_ff, t_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_norm_ff, rsp_norm_in;
   logic              rsp_end_ff, rsp_end_in;

   logic [ENT_W-1:0]  store_mem [MAX_ROW];
   logic [ENT_W-1:0]  rdata_ff;
   logic              rdv_ff, sqv_ff;
   logic signed [15:0] xq_ff;
   logic [31:0]       sq_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   logic              issue;
   logic              sum_clear;

   logic [ROW_W-1:0]  row_eff;
   logic [CNT_W-1:0]  n_cnt;
   logic              req_fire;
   logic signed [15:0] rd_x;
   logic [SUM_W-1:0]  s_abs;
   logic [33:0]       c_abs;
   logic [17:0]       f_abs;
   logic [WORD_W-1:0] rnd_c;
   logic [WORD_W-1:0] quo_eps;
   logic [WORD_W-1:0] t_abs;
   logic [WORD_W-1:0] r_mag;
   logic              last;

   unit_ctl_type      mul_ctl, div_ctl, sqrt_ctl;
   logic [WORD_W-1:0] mul_a, mul_b, mul_p;
   logic [WORD_W-1:0] div_n, div_d, div_q;
   logic [WORD_W-1:0] sqrt_r;

   assign row_eff  = (row_len_ff == '0) ? ROW_W'(1) : row_len_ff;
   assign n_cnt    = (32'(row_eff) > 32'(MAX_ROW)) ? CNT_W'(MAX_ROW) : CNT_W'(row_eff);
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rd_x      = signed'(rdata_ff[ENT_W-1 -: DATA_W]);
   assign s_abs     = s_ff[SUM_W-1] ? SUM_W'(-s_ff) : SUM_W'(s_ff);
   assign c_abs     = c_ff[33] ? 34'(-c_ff) : 34'(c_ff);
   assign f_abs     = f_ff[17] ? 18'(-f_ff) : 18'(f_ff);
   assign last      = (drain_ff + 1'b1) >= n_cnt;
   assign issue     = (state_ff == ST_SUM) && (pass_ff < n_cnt);
   assign rd_addr   = (state_ff == ST_SUM) ? pass_ff[AW-1:0] : drain_ff[AW-1:0];
   assign mem_we    = req_fire && (req_cmd == CMD_LOAD) && (loaded_ff < n_cnt);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[loaded_ff[AW-1:0]] <= {req_sample, req_shift_term, req_scale_term};
      end
      rdata_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         sqv_ff <= 1'b0;
      end else begin
         rdv_ff <= issue;
         sqv_ff <= rdv_ff;
      end
      xq_ff <= rd_x;
      sq_ff <= 32'(32'(rd_x) * 32'(rd_x));
      if (sum_clear) begin
         s_ff <= '0;
         q_ff <= '0;
      end else if (sqv_ff) begin
         s_ff <= s_ff + SUM_W'(xq_ff);
         q_ff <= q_ff + SQ_W'(sq_ff);
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = '0;
      div_d = WORD_W'(1);
      unique case (state_ff)
         ST_MUL_NQ: begin
            mul_a = WORD_W'(n_cnt);
            mul_b = WORD_W'(q_ff);
         end
         ST_MUL_SS: begin
            mul_a = WORD_W'(s_abs);
            mul_b = WORD_W'(s_abs);
         end
         ST_MUL_NN: begin
            mul_a = WORD_W'(n_cnt);
            mul_b = WORD_W'(n_cnt);
         end
         ST_MUL_C: begin
            mul_a = WORD_W'(c_abs);
            mul_b = WORD_W'(inv_ff);
         end
         ST_MUL_F: begin
            mul_a = WORD_W'(mmag_ff);
            mul_b = WORD_W'(f_abs);
         end
         ST_DIV_VAR: begin
            div_n = num_ff;
            div_d = nn_ff;
         end
         ST_DIV_MEAN: begin
            div_n = (WORD_W'(s_abs) << 12) + WORD_W'(n_cnt >> 1);
            div_d = WORD_W'(n_cnt);
         end
         ST_DIV_INV: begin
            div_n = WORD_W'(1) << (WORD_W - 2);
            div_d = dd_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_ctl.start  = !launch_ff && ((state_ff == ST_MUL_NQ) || (state_ff == ST_MUL_SS) ||
                           (state_ff == ST_MUL_NN) || (state_ff == ST_MUL_C) ||
                           (state_ff == ST_MUL_F));
   assign div_ctl.start  = !launch_ff && ((state_ff == ST_DIV_VAR) ||
                           (state_ff == ST_DIV_MEAN) || (state_ff == ST_DIV_INV));
   assign sqrt_ctl.start = !launch_ff && (state_ff == ST_SQRT);

   mln_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_ctl.start),
      .opa     (mul_a),
      .opb     (mul_b),
      .done    (mul_ctl.done),
      .product (mul_p)
   );

   mln_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_ctl.done),
      .quotient (div_q)
   );

   mln_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_ctl.start),
      .radicand (num_ff),
      .done     (sqrt_ctl.done),
      .root     (sqrt_r)
   );

   assign rnd_c   = mul_p + (WORD_W'(1) << 18);
   assign quo_eps = div_q + WORD_W'(eps_ff);
   assign t_abs   = t_ff[WORD_W-1] ? WORD_W'(-t_ff) : WORD_W'(t_ff);
   assign r_mag   = (t_abs + (WORD_W'(1) << 23)) >> 24;

   always_comb begin
      state_in     = state_ff;
      launch_in    = 1'b0;
      loaded_in    = loaded_ff;
      drain_in     = drain_ff;
      pass_in      = pass_ff;
      stats_in     = stats_ff;
      mean_in      = mean_ff;
      inv_in       = inv_ff;
      num_in       = num_ff;
      nn_in        = nn_ff;
      dd_in        = dd_ff;
      c_in         = c_ff;
      sh_in        = sh_ff;
      f_in         = f_ff;
      mmag_in      = mmag_ff;
      mneg_in      = mneg_ff;
      mf_in        = mf_ff;
      t_in         = t_ff;
      rsp_norm_in  = rsp_norm_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sum_clear    = 1'b0;
      if (issue) begin
         pass_in = pass_ff + 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_LOAD) begin
                  if (loaded_ff < n_cnt) begin
                     loaded_in = loaded_ff + 1'b1;
                  end
               end else if (loaded_ff >= n_cnt) begin
                  if (stats_ff) begin
                     state_in = ST_RD;
                  end else begin
                     state_in  = ST_SUM;
                     pass_in   = '0;
                     sum_clear = 1'b1;
                  end
               end
            end
         end
         ST_SUM: begin
            if (!issue && !rdv_ff && !sqv_ff) begin
               state_in = ST_MUL_NQ;
            end
         end
         ST_MUL_NQ: begin
            launch_in = !mul_ctl.done;
            if (mul_ctl.done) begin
               num_in   = mul_p;
               state_in = ST_MUL_SS;
            end
         end
         ST_MUL_SS: begin
            launch_in = !mul_ctl.done;
            if (mul_ctl.done) begin
               num_in   = num_ff - mul_p;
               state_in = ST_MUL_NN;
            end
         end
         ST_MUL_NN: begin
            launch_in = !mul_ctl.done;
            if (mul_ctl.done) begin
               nn_in    = mul_p;
               state_in = ST_DIV_VAR;
            end
         end
         ST_DIV_VAR: begin
            launch_in = !div_ctl.done;
            if (div_ctl.done) begin
               dd_in    = (quo_eps == '0) ? WORD_W'(1) : quo_eps;
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            launch_in = !div_ctl.done;
            if (div_ctl.done) begin
               mean_in  = s_ff[SUM_W-1] ? -signed'(div_q[31:0]) : signed'(div_q[31:0]);
               state_in = ST_DIV_INV;
            end
         end
         ST_DIV_INV: begin
            launch_in = !div_ctl.done;
            if (div_ctl.done) begin
               num_in   = div_q;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            launch_in = !sqrt_ctl.done;
            if (sqrt_ctl.done) begin
               inv_in   = sqrt_r[31:0];
               stats_in = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            c_in     = (34'(rd_x) <<< 12) - 34'(mean_ff);
            sh_in    = signed'(rdata_ff[2*DATA_W-1 -: DATA_W]);
            f_in     = 18'sd4096 + 18'(signed'(rdata_ff[DATA_W-1:0]));
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            launch_in = !mul_ctl.done;
            if (mul_ctl.done) begin
               mmag_in  = rnd_c[19 +: MAG_W];
               mneg_in  = c_ff[33];
               state_in = ST_MUL_F;
            end
         end
         ST_MUL_F: begin
            launch_in = !mul_ctl.done;
            if (mul_ctl.done) begin
               mf_in    = (mneg_ff ^ f_ff[17]) ? -signed'(mul_p) : signed'(mul_p);
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: begin
            t_in     = mf_ff + (WORD_W'(sh_ff) <<< 24);
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            if (t_ff[WORD_W-1]) begin
               rsp_norm_in = (r_mag > WORD_W'(32768)) ? -16'sd32768 : -signed'(r_mag[15:0]);
            end else begin
               rsp_norm_in = (r_mag > WORD_W'(32767)) ? 16'sd32767 : signed'(r_mag[15:0]);
            end
            rsp_end_in   = last;
            rsp_valid_in = 1'b1;
            if (last) begin
               loaded_in = '0;
               drain_in  = '0;
               stats_in  = 1'b0;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we && (csr_index == REG_ROW_LENGTH)) begin
         loaded_in = '0;
         drain_in  = '0;
         stats_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         loaded_ff    <= '0;
         drain_ff     <= '0;
         pass_ff      <= '0;
         stats_ff     <= 1'b0;
         mean_ff      <= '0;
         inv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         row_len_ff   <= ROW_LENGTH_RST;
         eps_ff       <= EPSILON_RST;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         loaded_ff    <= loaded_in;
         drain_ff     <= drain_in;
         pass_ff      <= pass_in;
         stats_ff     <= stats_in;
         mean_ff      <= mean_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == REG_ROW_LENGTH)) begin
            row_len_ff <= csr_data[ROW_W-1:0];
         end
         if (csr_we && (csr_index == REG_EPSILON)) begin
            eps_ff <= csr_data[EPS_W-1:0];
         end
      end
      num_ff      <= num_in;
      nn_ff       <= nn_in;
      dd_ff       <= dd_in;
      c_ff        <= c_in;
      sh_ff       <= sh_in;
      f_ff        <= f_in;
      mmag_ff     <= mmag_in;
      mneg_ff     <= mneg_in;
      mf_ff       <= mf_in;
      t_ff        <= t_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normalized = rsp_norm_ff;
   assign rsp_row_end    = rsp_end_ff;

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready while sequencer busy");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= n_cnt)
      else $error("loaded count beyond row length");

   a_stats_full: assert property (@(posedge clock) disable iff (reset)
      stats_ff |-> (loaded_ff == n_cnt))
      else $error("statistics held for a partial row");

   a_result_stats: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN2) |-> stats_ff)
      else $error("result produced without statistics");

endmodule

// ===== hw/rtl/mln_mul.sv =====
// ----------------------------------------------------------------------------
// mln_mul
// Shift-add multiplier, one multiplier bit per cycle, low word of product.
// ----------------------------------------------------------------------------
module mln_mul import mln_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] opa,
   input  logic [WORD_W-1:0] opb,
   output logic              done,
   output logic [WORD_W-1:0] product
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = {a_ff[WORD_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[WORD_W-1:1]};
         if (b_ff[WORD_W-1:1] == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = opa;
         b_in    = opb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== hw/rtl/mln_div.sv =====
// ----------------------------------------------------------------------------
// mln_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mln_div import mln_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   output logic              done,
   output logic [WORD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W:0]   rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [WORD_W:0]   rem_sh;
   logic [WORD_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[WORD_W-1:0], quo_ff[WORD_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/mln_sqrt.sv =====
// ----------------------------------------------------------------------------
// mln_sqrt
// Bitwise integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mln_sqrt import mln_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] radicand,
   output logic              done,
   output logic [WORD_W-1:0] root
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] r_ff, r_in;
   logic [WORD_W-1:0] bit_ff, bit_in;
   logic [WORD_W-1:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      trial   = r_ff + bit_ff;
      if (busy_ff) begin
         if (a_ff >= trial) begin
            a_in = a_ff - trial;
            r_in = {1'b0, r_ff[WORD_W-1:1]} + bit_ff;
         end else begin
            r_in = {1'b0, r_ff[WORD_W-1:1]};
         end
         bit_in = {2'b00, bit_ff[WORD_W-1:2]};
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         a_in    = radicand;
         r_in    = '0;
         bit_in  = WORD_W'(1) << (WORD_W - 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff;

endmodule
